// ===== src/sprite_table_dma_controller_top_macros.svh =====
// Assertion macros shared by the sprite-table DMA RTL.
`ifndef SPRITE_TABLE_DMA_CONTROLLER_TOP_MACROS_SVH
`define SPRITE_TABLE_DMA_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define STDMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stdma check failed");
`define STDMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stdma check failed");
`else
`define STDMA_ASSERT(lbl, prop)
`define STDMA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/stdma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stdma_pkg;

  localparam int QUEUE_DEPTH_DEF     = 3;
  localparam int TRANSFER_LENGTH_DEF = 160;

  localparam int PAGE_W = 8;
  localparam int CNT_W  = 8;
  localparam int ADDR_W = PAGE_W + CNT_W;

  localparam int CMDQ_DEPTH = 2;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  localparam logic [1:0] ST_ACTIVE    = 2'd0;
  localparam logic [1:0] ST_SETUP     = 2'd1;
  localparam logic [1:0] ST_REQUESTED = 2'd2;

  typedef struct packed {
    logic              is_tick;
    logic [PAGE_W-1:0] page;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/stdma_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface stdma_in_if
  import stdma_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [PAGE_W-1:0] source_page;

  modport source (output valid, kind, source_page, input ready);
  modport sink (input valid, kind, source_page, output ready);
endinterface

interface stdma_out_if
  import stdma_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              copy_valid;
  logic [ADDR_W-1:0] read_address;
  logic [CNT_W-1:0]  table_slot;
  logic              busy_res;
  logic              request_dropped;

  modport source (output valid, copy_valid, read_address, table_slot, busy_res,
                  request_dropped, input ready);
  modport sink (input valid, copy_valid, read_address, table_slot, busy_res,
                request_dropped, output ready);
endinterface

`default_nettype wire

// ===== src/sprite_table_dma_controller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sprite-table DMA controller.
// req channel: one word per item; kind 0 queues a transfer from source_page,
// kind 1 is a machine-cycle tick that advances every queued transfer.
// res channel: one word per accepted item; on ticks it carries the copy
// (read_address, table_slot) when one is made, plus the busy flag.
// A request that finds the transfer queue full sets request_dropped.
// Each item passes through the command FIFO and then the result register.
// Throughput: one item per cycle while res does not stall; the tick update of all
// queue entries and the shared byte counter are combinational in the execute stage.
// A 2-word command FIFO sits between intake and execute; when res stalls,
// the result register holds, the FIFO fills and req.ready drops when
// both FIFO words are taken.
// Reset: transfer queue empty, byte counter zero, busy clear, FIFO empty.

module sprite_table_dma_controller_top
  import stdma_pkg::*;
#(
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
  parameter int TRANSFER_LENGTH = TRANSFER_LENGTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  stdma_in_if.sink    req,
  stdma_out_if.source res
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  stdma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  stdma_engine #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .TRANSFER_LENGTH (TRANSFER_LENGTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res       (res)
  );

endmodule

`default_nettype wire

// ===== src/stdma_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "sprite_table_dma_controller_top_macros.svh"

module stdma_front
  import stdma_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  stdma_in_if.sink    req,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  wire logic   cmd_pop
);

  localparam int PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int FCNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t              fifo [CMDQ_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [FCNT_W-1:0] fcnt;
  logic              push;
  cmd_t              cmd_in;

  assign req.ready = (fcnt != FCNT_W'(CMDQ_DEPTH));
  assign push      = req.valid && req.ready;

  assign cmd_in.is_tick = (req.kind == KIND_TICK);
  assign cmd_in.page    = req.source_page;

  assign cmd_valid = (fcnt != '0);
  assign cmd       = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fcnt <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (cmd_pop) begin
        rptr <= (rptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, cmd_pop})
        2'b10:   fcnt <= fcnt + 1'b1;
        2'b01:   fcnt <= fcnt - 1'b1;
        default: fcnt <= fcnt;
      endcase
    end
  end

  `STDMA_ASSERT(a_front_no_pop_empty, cmd_pop |-> cmd_valid)
  `STDMA_ASSERT_NEXT(a_front_full_holds, (fcnt == FCNT_W'(CMDQ_DEPTH)) && !cmd_pop,
                     !req.ready)

endmodule

`default_nettype wire

// ===== src/stdma_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "sprite_table_dma_controller_top_macros.svh"

module stdma_engine
  import stdma_pkg::*;
#(
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
  parameter int TRANSFER_LENGTH = TRANSFER_LENGTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cmd_valid,
  input  wire cmd_t   cmd,
  output logic        cmd_pop,
  stdma_out_if.source res
);

  localparam int CNT_Q_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W:0] LEN_LIM = (CNT_W + 1)'(TRANSFER_LENGTH);

  logic [PAGE_W-1:0]  qpage      [QUEUE_DEPTH];
  logic [1:0]         qstat      [QUEUE_DEPTH];
  logic [PAGE_W-1:0]  qpage_next [QUEUE_DEPTH];
  logic [1:0]         qstat_next [QUEUE_DEPTH];
  logic [CNT_Q_W-1:0] qcount;
  logic [CNT_Q_W-1:0] qcount_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic               flag;
  logic               flag_next;
  logic [CNT_W:0]     sum;
  logic               deq;
  logic               copy;
  logic [ADDR_W-1:0]  addr;
  logic [CNT_W-1:0]   slot;
  logic               dropped;
  logic               go;

  assign go      = cmd_valid && (!res.valid || res.ready);
  assign cmd_pop = go;

  always_comb begin
    qpage_next  = qpage;
    qstat_next  = qstat;
    qcount_next = qcount;
    cnt_next    = cnt;
    flag_next   = flag;
    sum         = '0;
    deq         = 1'b0;
    copy        = 1'b0;
    addr        = '0;
    slot        = '0;
    dropped     = 1'b0;
    if (cmd.is_tick) begin
      // walk from head; active entries share the running byte count
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (CNT_Q_W'(i) < qcount) begin
          case (qstat[i])
            ST_REQUESTED: begin
              qstat_next[i] = ST_SETUP;
            end
            ST_SETUP: begin
              qstat_next[i] = ST_ACTIVE;
              flag_next     = 1'b1;
              cnt_next      = '0;
              if (i > 0) begin
                deq = 1'b1;
              end
            end
            ST_ACTIVE: begin
              copy = 1'b1;
              addr = {qpage[i], cnt_next};
              slot = cnt_next;
              sum  = (CNT_W + 1)'(cnt_next) + 1'b1;
              if (sum >= LEN_LIM) begin
                flag_next = 1'b0;
                cnt_next  = '0;
                deq       = 1'b1;
              end else begin
                cnt_next = sum[CNT_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      if (deq) begin
        for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
          qstat_next[j] = qstat_next[j+1];
          qpage_next[j] = qpage_next[j+1];
        end
        qcount_next = qcount - 1'b1;
      end
    end else begin
      if (qcount == CNT_Q_W'(QUEUE_DEPTH)) begin
        dropped = 1'b1;
      end else begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          if (CNT_Q_W'(j) == qcount) begin
            qpage_next[j] = cmd.page;
            qstat_next[j] = ST_REQUESTED;
          end
        end
        qcount_next = qcount + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      qpage               <= qpage_next;
      qstat               <= qstat_next;
      res.copy_valid      <= copy;
      res.read_address    <= addr;
      res.table_slot      <= slot;
      res.busy_res        <= flag_next;
      res.request_dropped <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount    <= '0;
      cnt       <= '0;
      flag      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (go) begin
        qcount <= qcount_next;
        cnt    <= cnt_next;
        flag   <= flag_next;
      end
      if (go) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  `STDMA_ASSERT(a_qcount_bound, qcount <= CNT_Q_W'(QUEUE_DEPTH))
  `STDMA_ASSERT(a_cnt_bound, (CNT_W + 1)'(cnt) < LEN_LIM)
  `STDMA_ASSERT_NEXT(a_tick_never_drops, go && cmd.is_tick, !res.request_dropped)
  `STDMA_ASSERT_NEXT(a_request_no_copy, go && !cmd.is_tick,
                     !res.copy_valid && (res.busy_res == $past(flag)))

endmodule

`default_nettype wire
